// ----- src/dst_pkg.sv -----
// dst_pkg: shared types, operation and status codes, and the control bundles
// that pass between the slot table controller and its datapath
// no dependencies
`default_nettype none

package dst_pkg;

	typedef logic [2:0]  func_t;
	typedef logic [2:0]  status_t;
	typedef logic [2:0]  slot_t;
	typedef logic [31:0] dev_id_t;
	typedef logic [31:0] handle_t;
	typedef logic [7:0]  dtype_t;
	typedef logic [7:0]  rank_t;
	typedef logic [3:0]  vcount_t;

	// operation codes
	localparam func_t FN_CONNECT    = 3'd0;
	localparam func_t FN_DISCONNECT = 3'd1;
	localparam func_t FN_FIND       = 3'd2;
	localparam func_t FN_GET        = 3'd3;
	localparam func_t FN_CLEAR      = 3'd4;

	// result status codes
	localparam status_t ST_CONNECTED    = 3'd0;
	localparam status_t ST_DISCONNECTED = 3'd1;
	localparam status_t ST_FOUND        = 3'd2;
	localparam status_t ST_NOT_FOUND    = 3'd3;
	localparam status_t ST_REJECTED     = 3'd4;
	localparam status_t ST_FULL         = 3'd5;

	// controller to datapath
	typedef struct packed {
		logic take;
		logic eval;
		logic decide;
		logic scan;
		logic pick;
		logic post;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic no_result;
		logic go_scan;
		logic go_pick;
		logic scan_hit;
		logic pend_any;
		logic out_free;
	} sts_t;

endpackage

`default_nettype wire

// ----- src/dst_ctrl.sv -----
// dst_ctrl: sequencing state machine of the device slot table
// depends on dst_pkg
`default_nettype none

module dst_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_stall,
	output dst_pkg::cmd_t      cmd,
	input  wire dst_pkg::sts_t sts
);

	typedef enum logic [5:0] {
		S_IDLE   = 6'b000001,
		S_EVAL   = 6'b000010,
		S_DECIDE = 6'b000100,
		S_SCAN   = 6'b001000,
		S_PICK   = 6'b010000,
		S_POST   = 6'b100000
	} state_t;

	state_t state_q;
	state_t state_n;

	always_comb begin
		state_n = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.take = 1'b1;
					state_n  = S_EVAL;
				end
			end
			S_EVAL: begin
				cmd.eval = 1'b1;
				state_n  = S_DECIDE;
			end
			S_DECIDE: begin
				cmd.decide = 1'b1;
				if (sts.no_result) begin
					state_n = S_IDLE;
				end else if (sts.go_scan) begin
					state_n = S_SCAN;
				end else if (sts.go_pick) begin
					state_n = S_PICK;
				end else begin
					state_n = S_POST;
				end
			end
			S_SCAN: begin
				cmd.scan = 1'b1;
				if (sts.scan_hit) begin
					state_n = S_POST;
				end
			end
			S_PICK: begin
				cmd.pick = 1'b1;
				state_n  = S_POST;
			end
			S_POST: begin
				if (sts.out_free) begin
					cmd.post = 1'b1;
					state_n  = sts.pend_any ? S_PICK : S_IDLE;
				end
			end
			default: begin
				state_n = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	assign in_stall = (state_q != S_IDLE);

endmodule

`default_nettype wire

// ----- src/dst_datapath.sv -----
// dst_datapath: slot table storage, id compare, slot picks, rank scan,
// result staging and output register
// depends on dst_pkg
`default_nettype none

module dst_datapath #(
	parameter int SLOTS = 8
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire dst_pkg::func_t    func,
	input  wire dst_pkg::dev_id_t  dev_id,
	input  wire dst_pkg::handle_t  dev_handle,
	input  wire dst_pkg::dtype_t   dev_type,
	input  wire logic              dev_console,
	input  wire dst_pkg::rank_t    rank,
	input  wire logic              out_stall,
	output logic                   out_valid,
	output dst_pkg::status_t       status,
	output dst_pkg::slot_t         slot,
	output dst_pkg::dev_id_t       entry_id,
	output dst_pkg::handle_t       entry_handle,
	output dst_pkg::dtype_t        entry_type,
	output logic                   entry_console,
	output dst_pkg::vcount_t       valid_count,
	output logic                   last,
	input  wire dst_pkg::cmd_t     cmd,
	output dst_pkg::sts_t          sts
);

	localparam int SW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CW    = $clog2(SLOTS + 1);
	localparam int CMP_W = (CW > 8) ? CW + 1 : 9;

	function automatic logic [SW-1:0] lowest(input logic [SLOTS-1:0] v);
		logic [SW-1:0] r;
		r = '0;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (v[i]) begin
				r = SW'(i);
			end
		end
		return r;
	endfunction

	// request held for the whole operation
	dst_pkg::func_t   func_q;
	dst_pkg::dev_id_t id_q;
	dst_pkg::handle_t handle_q;
	dst_pkg::dtype_t  dtype_q;
	logic             cons_q;
	dst_pkg::rank_t   rank_q;

	// table control state
	logic [SLOTS-1:0] valid_q;
	logic [SLOTS-1:0] pend_q;
	logic [CW-1:0]    count_q;

	// id copies for the parallel compare
	dst_pkg::dev_id_t ids_q [SLOTS];

	// entry memory
	dst_pkg::dev_id_t mem_id     [SLOTS];
	dst_pkg::handle_t mem_handle [SLOTS];
	dst_pkg::dtype_t  mem_type   [SLOTS];
	logic             mem_cons   [SLOTS];
	dst_pkg::dev_id_t rd_id_q;
	dst_pkg::handle_t rd_handle_q;
	dst_pkg::dtype_t  rd_type_q;
	logic             rd_cons_q;

	// lookup results
	logic             match_hit_q;
	logic [SW-1:0]    match_idx_q;
	logic             free_hit_q;
	logic [SW-1:0]    free_idx_q;

	// rank scan
	logic [SW-1:0]    scan_q;
	dst_pkg::rank_t   left_q;

	// staged result
	dst_pkg::status_t stg_status_q;
	logic [SW-1:0]    stg_idx_q;
	logic             stg_has_q;
	logic             stg_fromin_q;
	logic             stg_last_q;
	logic [CW-1:0]    stg_cnt_q;

	// output register
	logic             out_valid_q;
	dst_pkg::status_t status_q;
	dst_pkg::slot_t   slot_q;
	dst_pkg::dev_id_t entry_id_q;
	dst_pkg::handle_t entry_handle_q;
	dst_pkg::dtype_t  entry_type_q;
	logic             entry_console_q;
	dst_pkg::vcount_t valid_count_q;
	logic             last_q;

	logic [SLOTS-1:0] hit_vec;
	logic [SW-1:0]    pend_low;
	logic [SLOTS-1:0] pend_rest;
	logic             rank_ok;
	logic             scan_valid;
	logic             out_free;

	logic             stg_ld;
	dst_pkg::status_t st_n;
	logic [SW-1:0]    idx_n;
	logic             has_n;
	logic             fromin_n;
	logic             last_n;
	logic [CW-1:0]    cnt_n;
	logic             rd_en;
	logic [SW-1:0]    rd_addr;
	logic             do_conn;
	logic             do_disc;
	logic             do_clear;
	logic             scan_init;
	logic             scan_adv;
	logic             left_dec;
	logic             pend_pop;

	always_comb begin
		for (int i = 0; i < SLOTS; i++) begin
			hit_vec[i] = valid_q[i] && (ids_q[i] == id_q);
		end
	end

	assign pend_low   = lowest(pend_q);
	assign pend_rest  = pend_q & ~(SLOTS'(1) << pend_low);
	assign rank_ok    = CMP_W'(rank_q) < CMP_W'(count_q);
	assign scan_valid = valid_q[scan_q];
	assign out_free   = !out_valid_q || !out_stall;

	always_comb begin
		stg_ld    = 1'b0;
		st_n      = dst_pkg::ST_NOT_FOUND;
		idx_n     = '0;
		has_n     = 1'b0;
		fromin_n  = 1'b0;
		last_n    = 1'b1;
		cnt_n     = count_q;
		rd_en     = 1'b0;
		rd_addr   = match_idx_q;
		do_conn   = 1'b0;
		do_disc   = 1'b0;
		do_clear  = 1'b0;
		scan_init = 1'b0;
		scan_adv  = 1'b0;
		left_dec  = 1'b0;
		pend_pop  = 1'b0;
		if (cmd.decide) begin
			case (func_q)
				dst_pkg::FN_CONNECT: begin
					stg_ld = 1'b1;
					if ((id_q == '0) || match_hit_q) begin
						st_n = dst_pkg::ST_REJECTED;
					end else if (free_hit_q) begin
						st_n     = dst_pkg::ST_CONNECTED;
						idx_n    = free_idx_q;
						has_n    = 1'b1;
						fromin_n = 1'b1;
						cnt_n    = count_q + CW'(1);
						do_conn  = 1'b1;
					end else begin
						st_n = dst_pkg::ST_FULL;
					end
				end
				dst_pkg::FN_DISCONNECT: begin
					stg_ld = 1'b1;
					if (match_hit_q) begin
						st_n    = dst_pkg::ST_DISCONNECTED;
						idx_n   = match_idx_q;
						has_n   = 1'b1;
						rd_en   = 1'b1;
						cnt_n   = count_q - CW'(1);
						do_disc = 1'b1;
					end
				end
				dst_pkg::FN_FIND: begin
					stg_ld = 1'b1;
					if (match_hit_q) begin
						st_n  = dst_pkg::ST_FOUND;
						idx_n = match_idx_q;
						has_n = 1'b1;
						rd_en = 1'b1;
					end
				end
				dst_pkg::FN_GET: begin
					if (rank_ok) begin
						scan_init = 1'b1;
					end else begin
						stg_ld = 1'b1;
					end
				end
				dst_pkg::FN_CLEAR: begin
					do_clear = 1'b1;
					cnt_n    = '0;
					// empty table gives a single not-found result
					if (valid_q == '0) begin
						stg_ld = 1'b1;
					end
				end
				default: begin
				end
			endcase
		end else if (cmd.scan) begin
			scan_adv = 1'b1;
			if (scan_valid) begin
				if (left_q == '0) begin
					stg_ld  = 1'b1;
					st_n    = dst_pkg::ST_FOUND;
					idx_n   = scan_q;
					has_n   = 1'b1;
					rd_en   = 1'b1;
					rd_addr = scan_q;
				end else begin
					left_dec = 1'b1;
				end
			end
		end else if (cmd.pick) begin
			stg_ld   = 1'b1;
			st_n     = dst_pkg::ST_DISCONNECTED;
			idx_n    = pend_low;
			has_n    = 1'b1;
			rd_en    = 1'b1;
			rd_addr  = pend_low;
			cnt_n    = '0;
			last_n   = (pend_rest == '0);
			pend_pop = 1'b1;
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= '0;
			pend_q      <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (do_conn) begin
				valid_q[free_idx_q] <= 1'b1;
			end
			if (do_disc) begin
				valid_q[match_idx_q] <= 1'b0;
			end
			if (do_clear) begin
				pend_q  <= valid_q;
				valid_q <= '0;
			end
			if (pend_pop) begin
				pend_q <= pend_rest;
			end
			if (do_conn || do_disc || do_clear) begin
				count_q <= cnt_n;
			end
			if (cmd.post) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload and storage
	always_ff @(posedge clk) begin
		if (cmd.take) begin
			func_q   <= func;
			id_q     <= dev_id;
			handle_q <= dev_handle;
			dtype_q  <= dev_type;
			cons_q   <= dev_console;
			rank_q   <= rank;
		end
		if (cmd.eval) begin
			match_hit_q <= |hit_vec;
			match_idx_q <= lowest(hit_vec);
			free_hit_q  <= ~&valid_q;
			free_idx_q  <= lowest(~valid_q);
		end
		if (do_conn) begin
			ids_q[free_idx_q]      <= id_q;
			mem_id[free_idx_q]     <= id_q;
			mem_handle[free_idx_q] <= handle_q;
			mem_type[free_idx_q]   <= dtype_q;
			mem_cons[free_idx_q]   <= cons_q;
		end
		if (rd_en) begin
			rd_id_q     <= mem_id[rd_addr];
			rd_handle_q <= mem_handle[rd_addr];
			rd_type_q   <= mem_type[rd_addr];
			rd_cons_q   <= mem_cons[rd_addr];
		end
		if (scan_init) begin
			scan_q <= '0;
			left_q <= rank_q;
		end
		if (scan_adv) begin
			scan_q <= scan_q + SW'(1);
		end
		if (left_dec) begin
			left_q <= left_q - 8'd1;
		end
		if (stg_ld) begin
			stg_status_q <= st_n;
			stg_idx_q    <= idx_n;
			stg_has_q    <= has_n;
			stg_fromin_q <= fromin_n;
			stg_last_q   <= last_n;
			stg_cnt_q    <= cnt_n;
		end
		if (cmd.post) begin
			status_q      <= stg_status_q;
			slot_q        <= stg_has_q ? dst_pkg::slot_t'(stg_idx_q) : '0;
			valid_count_q <= dst_pkg::vcount_t'(stg_cnt_q);
			last_q        <= stg_last_q;
			if (!stg_has_q) begin
				entry_id_q      <= '0;
				entry_handle_q  <= '0;
				entry_type_q    <= '0;
				entry_console_q <= 1'b0;
			end else if (stg_fromin_q) begin
				entry_id_q      <= id_q;
				entry_handle_q  <= handle_q;
				entry_type_q    <= dtype_q;
				entry_console_q <= cons_q;
			end else begin
				entry_id_q      <= rd_id_q;
				entry_handle_q  <= rd_handle_q;
				entry_type_q    <= rd_type_q;
				entry_console_q <= rd_cons_q;
			end
		end
	end

	always_comb begin
		sts.no_result = !((func_q == dst_pkg::FN_CONNECT) || (func_q == dst_pkg::FN_DISCONNECT) ||
			(func_q == dst_pkg::FN_FIND) || (func_q == dst_pkg::FN_GET) ||
			(func_q == dst_pkg::FN_CLEAR));
		sts.go_scan   = (func_q == dst_pkg::FN_GET) && rank_ok;
		sts.go_pick   = (func_q == dst_pkg::FN_CLEAR) && (valid_q != '0);
		sts.scan_hit  = scan_valid && (left_q == '0);
		sts.pend_any  = |pend_q;
		sts.out_free  = out_free;
	end

	assign out_valid     = out_valid_q;
	assign status        = status_q;
	assign slot          = slot_q;
	assign entry_id      = entry_id_q;
	assign entry_handle  = entry_handle_q;
	assign entry_type    = entry_type_q;
	assign entry_console = entry_console_q;
	assign valid_count   = valid_count_q;
	assign last          = last_q;

endmodule

`default_nettype wire

// ----- src/device_slot_table.sv -----
// device_slot_table: top level of the device slot table
// depends on dst_pkg, dst_ctrl, dst_datapath
//
//   channel   handshake             payload
//   request   in_valid / in_stall   func, dev_id, dev_handle, dev_type,
//                                   dev_console, rank
//   result    out_valid / out_stall status, slot, entry_id, entry_handle,
//                                   entry_type, entry_console, valid_count, last
//
// one request at a time: connect, disconnect and find hold the request channel
// through take, id compare, decide and post; get with a rank in range adds a
// scan step per slot up to the wanted one (at most SLOTS); clear adds an entry
// read and a post per valid slot, or a single post on an empty table
// arst_n clears the valid marks, the count and the result valid flag; entry
// contents stay undefined until written
// a finished result waits in the output register while out_stall is high;
// the next request is taken once the previous result is in that register
`default_nettype none

module device_slot_table #(
	parameter int SLOTS = 8
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	// request channel
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire dst_pkg::func_t    func,
	input  wire dst_pkg::dev_id_t  dev_id,
	input  wire dst_pkg::handle_t  dev_handle,
	input  wire dst_pkg::dtype_t   dev_type,
	input  wire logic              dev_console,
	input  wire dst_pkg::rank_t    rank,
	// result channel
	output logic                   out_valid,
	input  wire logic              out_stall,
	output dst_pkg::status_t       status,
	output dst_pkg::slot_t         slot,
	output dst_pkg::dev_id_t       entry_id,
	output dst_pkg::handle_t       entry_handle,
	output dst_pkg::dtype_t        entry_type,
	output logic                   entry_console,
	output dst_pkg::vcount_t       valid_count,
	output logic                   last
);

	dst_pkg::cmd_t cmd;
	dst_pkg::sts_t sts;

	// sequencer: one request walks idle, compare, decide, then scan or pick
	// steps where needed, and waits in post until the result register frees
	dst_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.cmd      (cmd),
		.sts      (sts)
	);

	// table, compare and pick logic, entry memory, result register
	dst_datapath #(
		.SLOTS (SLOTS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.func          (func),
		.dev_id        (dev_id),
		.dev_handle    (dev_handle),
		.dev_type      (dev_type),
		.dev_console   (dev_console),
		.rank          (rank),
		.out_stall     (out_stall),
		.out_valid     (out_valid),
		.status        (status),
		.slot          (slot),
		.entry_id      (entry_id),
		.entry_handle  (entry_handle),
		.entry_type    (entry_type),
		.entry_console (entry_console),
		.valid_count   (valid_count),
		.last          (last),
		.cmd           (cmd),
		.sts           (sts)
	);

	// a taken request closes the request channel on the next cycle
	a_take_then_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("request channel still open after a request was taken");

	// connected, rejected, full and found results always mark their result as last
	a_connect_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (status == dst_pkg::ST_CONNECTED || status == dst_pkg::ST_REJECTED ||
		status == dst_pkg::ST_FULL || status == dst_pkg::ST_FOUND)) |-> last)
		else $error("single result without last");

	// results that name no slot carry zero entry fields
	a_no_entry_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (status == dst_pkg::ST_NOT_FOUND || status == dst_pkg::ST_REJECTED ||
		status == dst_pkg::ST_FULL)) |->
		(slot == '0 && entry_id == '0 && entry_handle == '0 && entry_type == '0 &&
		!entry_console))
		else $error("entry fields set on a result without a slot");

	// a fresh connection never stores the reserved id
	a_connect_id_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == dst_pkg::ST_CONNECTED) |-> (entry_id != '0))
		else $error("connected with id zero");

endmodule

`default_nettype wire
